>>> design/double_ended_queue_assert.svh
// ---------------------------------------------------------------------------
// Double-ended queue assertion macros
// Concurrent assertion shorthands, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deque assertion failed");

// next-cycle implication
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deque assertion failed");

`else

`define DEQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DEQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/deq_pkg.sv
// ---------------------------------------------------------------------------
// Deque package
// Shared types, command and status codes for the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int DEQ_DEPTH = 16;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_PEEK_FRONT = 3'd4;
  localparam logic [2:0] CMD_PEEK_BACK  = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic        [2:0]  command;
    logic signed [31:0] push_value;
  } deq_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [1:0]  status;
  } deq_out_t;

  // memory strobes from control to ring store
  typedef struct packed {
    logic rd;
    logic wr;
  } deq_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } deq_state_t;

endpackage

>>> design/deq_ram.sv
// ---------------------------------------------------------------------------
// Deque ring store
// Single-port synchronous memory, registered read data.
// ---------------------------------------------------------------------------
module deq_ram #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                        clk,
  input  deq_pkg::deq_mem_ctl_t       mem_ctl,
  input  logic [$clog2(DEPTH)-1:0]    addr,
  input  logic [31:0]                 wdata,
  output logic [31:0]                 rdata
);
  import deq_pkg::*;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (mem_ctl.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_ctl.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> design/deq_ctrl.sv
// ---------------------------------------------------------------------------
// Deque control
// Sequencer, end indices and fill count; drives the ring store.
// ---------------------------------------------------------------------------
module deq_ctrl #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  deq_pkg::deq_in_t            in_item,
  output logic                        out_strobe,
  output deq_pkg::deq_out_t           out_item,
  output deq_pkg::deq_mem_ctl_t       mem_ctl,
  output logic [$clog2(DEPTH)-1:0]    mem_addr,
  output logic [31:0]                 mem_wdata,
  input  logic [31:0]                 mem_rdata
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  deq_state_t state_r, state_nxt;

  logic [IDX_W-1:0] front_r, front_nxt;
  logic [IDX_W-1:0] back_r, back_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             use_rd_r, use_rd_nxt;
  deq_in_t          item_r;

  logic             accept;
  logic             exec;
  logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
  logic             is_full, is_empty;

  // FSM next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RESP;
      ST_RESP: state_nxt = start ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    busy       = 1'b0;
    exec       = 1'b0;
    out_strobe = 1'b0;
    case (state_r)
      ST_IDLE: ;
      ST_EXEC: begin
        busy = 1'b1;
        exec = 1'b1;
      end
      ST_RESP: out_strobe = 1'b1;
      default: ;
    endcase
  end

  assign accept = start && !busy;

  assign front_inc = (front_r == IDX_LAST) ? '0 : front_r + 1'b1;
  assign front_dec = (front_r == '0) ? IDX_LAST : front_r - 1'b1;
  assign back_inc  = (back_r == IDX_LAST) ? '0 : back_r + 1'b1;
  assign back_dec  = (back_r == '0) ? IDX_LAST : back_r - 1'b1;
  assign is_full   = (count_r == CNT_FULL);
  assign is_empty  = (count_r == '0);

  // command decode: at most one memory access, at most one index move
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    status_nxt = STAT_OK;
    use_rd_nxt = 1'b0;
    mem_ctl    = '0;
    mem_addr   = front_r;
    mem_wdata  = item_r.push_value;
    if (exec) begin
      case (item_r.command)
        CMD_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = STAT_FULL;
          end else begin
            mem_ctl.wr = 1'b1;
            mem_addr   = front_dec;
            front_nxt  = front_dec;
            count_nxt  = count_r + 1'b1;
          end
        end
        CMD_PUSH_BACK: begin
          if (is_full) begin
            status_nxt = STAT_FULL;
          end else begin
            mem_ctl.wr = 1'b1;
            mem_addr   = back_r;
            back_nxt   = back_inc;
            count_nxt  = count_r + 1'b1;
          end
        end
        CMD_POP_FRONT: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            mem_ctl.rd = 1'b1;
            use_rd_nxt = 1'b1;
            mem_addr   = front_r;
            front_nxt  = front_inc;
            count_nxt  = count_r - 1'b1;
          end
        end
        CMD_POP_BACK: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            mem_ctl.rd = 1'b1;
            use_rd_nxt = 1'b1;
            mem_addr   = back_dec;
            back_nxt   = back_dec;
            count_nxt  = count_r - 1'b1;
          end
        end
        CMD_PEEK_FRONT: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            mem_ctl.rd = 1'b1;
            use_rd_nxt = 1'b1;
            mem_addr   = front_r;
          end
        end
        CMD_PEEK_BACK: begin
          if (is_empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            mem_ctl.rd = 1'b1;
            use_rd_nxt = 1'b1;
            mem_addr   = back_dec;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      front_r  <= '0;
      back_r   <= '0;
      count_r  <= '0;
      status_r <= STAT_OK;
      use_rd_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
      if (exec) begin
        status_r <= status_nxt;
        use_rd_r <= use_rd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign out_item.result_value = use_rd_r ? mem_rdata : '0;
  assign out_item.status       = status_r;

endmodule

>>> design/double_ended_queue.sv
// ---------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of signed 32-bit values with push, pop and peek at
// both ends; one result transaction per command.
// ---------------------------------------------------------------------------
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------
//  command   | start, busy, in_item       | taken when start && !busy
//  result    | out_strobe, out_item       | one-cycle strobe, no backpressure
//
//  Sequence: a command accepted at edge N is executed in the following
//  cycle (index update plus one ring store access) and its result is
//  strobed in the cycle after that. The next command may be accepted while
//  that result is shown, but not while one executes; the single-port ring
//  store has registered read data.
//  Reset: synchronous, active low; indices and count clear at once, the
//  store itself is not cleared (entries are read only after being written).
//  Stalls: busy is high only during the execute cycle; the receiver cannot
//  stall, every result is taken in its strobe cycle.
//
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  deq_pkg::deq_in_t    in_item,
  output logic                out_strobe,
  output deq_pkg::deq_out_t   out_item
);
  import deq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  deq_mem_ctl_t     mem_ctl;
  logic [IDX_W-1:0] mem_addr;
  logic [31:0]      mem_wdata;
  logic [31:0]      mem_rdata;

  // sequencer, indices and fill count
  deq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .mem_ctl   (mem_ctl),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // ring store: at most one access per command; read data lands for the strobe
  deq_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .mem_ctl(mem_ctl),
    .addr   (mem_addr),
    .wdata  (mem_wdata),
    .rdata  (mem_rdata)
  );

  // accepted command is executed next cycle
  `DEQ_ASSERT_NXT(a_accept_exec, clk, rst_n, start && !busy, busy)
  // execute cycle is always followed by its result strobe
  `DEQ_ASSERT_NXT(a_exec_strobe, clk, rst_n, busy, out_strobe && !busy)
  // error results carry a zero value
  `DEQ_ASSERT_IMP(a_err_zero, clk, rst_n, out_strobe && (out_item.status != STAT_OK),
                  out_item.result_value == '0)
  // single port: never read and write together, and only while executing
  `DEQ_ASSERT_IMP(a_mem_port, clk, rst_n, mem_ctl.rd || mem_ctl.wr,
                  busy && !(mem_ctl.rd && mem_ctl.wr))

endmodule

>>> tb/tb.sv
// ---------------------------------------------------------------------------
// Double-ended queue testbench
// Drives command transactions through the start/busy handshake and checks
// every strobed result, field by field, against a ring-buffer predictor.
// A short table of directed commands is run first: empty-queue errors,
// unused command codes, extreme values, a fill to full with push errors at
// both ends, and index wrap at both ends. Random traffic follows. It runs in
// segments that lean toward filling, draining or neither, so the queue
// swings between empty and full many times.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  // command codes the block must ignore
  localparam logic [2:0] CMD_UNUSED_6 = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7 = 3'd7;

  localparam int RANDOM_COMMANDS = 800;  // push/pop/peek transactions
  localparam int QUIET_TAIL      = 100;  // last random transactions, no idling
  localparam int STALL_LIMIT     = 200;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES    = 10;   // hold-off after the last result
  localparam int MAX_PRINTED     = 100;  // cap on printed mismatch lines

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  // one row of the directed table; want is used only where fixed is set
  typedef struct {
    logic [2:0]         cmd;
    logic signed [31:0] value;
    int                 reps;
    bit                 fixed;
    deq_out_t           want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  deq_in_t  in_item;
  logic     out_strobe;
  deq_out_t out_item;

  // travels with in_item: a typed-in expectation for this transaction
  bit       want_fixed;
  deq_out_t fixed_result;

  double_ended_queue dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Predictor: its own ring store, end slots and fill level
  // -------------------------------------------------------------------------
  logic signed [31:0] ring_store [DEQ_DEPTH];
  int                 head_slot  = 0;  // slot of the front element
  int                 tail_slot  = 0;  // slot one past the back element
  int                 fill_level = 0;  // elements held

  deq_out_t expected_results [$];
  int       error_count = 0;
  int       idle_cycles = 0;

  function automatic int slot_after(input int s);
    return (s == DEQ_DEPTH - 1) ? 0 : s + 1;
  endfunction

  function automatic int slot_before(input int s);
    return (s == 0) ? DEQ_DEPTH - 1 : s - 1;
  endfunction

  // applies one command to the predictor state and returns its result
  function automatic deq_out_t predict_deque_op(input deq_in_t op);
    deq_out_t r;
    r.result_value = '0;
    r.status       = STAT_OK;
    case (op.command)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill_level >= DEQ_DEPTH) begin
          r.status = STAT_FULL;
        end else if (op.command == CMD_PUSH_FRONT) begin
          head_slot = slot_before(head_slot);
          ring_store[head_slot] = op.push_value;
          fill_level++;
        end else begin
          ring_store[tail_slot] = op.push_value;
          tail_slot = slot_after(tail_slot);
          fill_level++;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK, CMD_PEEK_FRONT, CMD_PEEK_BACK: begin
        if (fill_level == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          case (op.command)
            CMD_POP_FRONT: begin
              r.result_value = ring_store[head_slot];
              head_slot = slot_after(head_slot);
              fill_level--;
            end
            CMD_POP_BACK: begin
              tail_slot = slot_before(tail_slot);
              r.result_value = ring_store[tail_slot];
              fill_level--;
            end
            CMD_PEEK_FRONT: r.result_value = ring_store[head_slot];
            default:        r.result_value = ring_store[slot_before(tail_slot)];
          endcase
        end
      end
      default: ;  // unused codes: no state change, zero and ok
    endcase
    return r;
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t ns mismatch: %s", $realtime, what);
  endtask

  // -------------------------------------------------------------------------
  // Monitor and watchdog. Everything is sampled at the rising edge; inputs
  // were set at the falling edge, so nothing here races the block.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    deq_out_t exp;
    bit       moved;
    moved = 1'b0;
    if (rst_n === 1'b1) begin
      // result transaction: compare with the oldest expectation
      if (out_strobe === 1'b1) begin
        moved = 1'b1;
        if (expected_results.size() == 0) begin
          flag_error($sformatf("result %0d/%0d with nothing expected",
                               out_item.result_value, out_item.status));
        end else begin
          exp = expected_results.pop_front();
          if (out_item.result_value !== exp.result_value)
            flag_error($sformatf("result_value got %0d want %0d",
                                 out_item.result_value, exp.result_value));
          if (out_item.status !== exp.status)
            flag_error($sformatf("status got %0d want %0d",
                                 out_item.status, exp.status));
        end
      end
      // command transaction: predict at the edge that takes it
      if (start === 1'b1 && busy === 1'b0) begin
        moved = 1'b1;
        exp = predict_deque_op(in_item);
        if (want_fixed)
          exp = fixed_result;
        expected_results.push_back(exp);
      end
    end
    if (moved) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t ns timeout: no transaction for %0d cycles", $realtime, STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Driver helpers. Both are entered at a falling edge and return at one.
  // -------------------------------------------------------------------------

  // holds start high until the block takes the command
  task automatic send_command(input logic [2:0] cmd, input logic signed [31:0] value,
                              input bit fixed, input deq_out_t want);
    in_item.command    <= cmd;
    in_item.push_value <= value;
    want_fixed         <= fixed;
    fixed_result       <= want;
    start              <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
  endtask

  // random idle burst, taken pct percent of the time
  task automatic idle_gap(input int pct);
    int n;
    if (pct > 0 && $urandom_range(0, 99) < pct) begin
      n = $urandom_range(1, 7);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  stim_row_t directed_rows [$];

  task automatic add_row(input logic [2:0] cmd, input logic signed [31:0] value,
                         input int reps, input bit fixed,
                         input logic signed [31:0] want_value, input logic [1:0] want_status);
    stim_row_t row;
    row.cmd                 = cmd;
    row.value               = value;
    row.reps                = reps;
    row.fixed               = fixed;
    row.want.result_value   = want_value;
    row.want.status         = want_status;
    directed_rows.push_back(row);
  endtask

  // -------------------------------------------------------------------------
  // Stimulus
  // -------------------------------------------------------------------------
  initial begin
    stim_row_t          row;
    deq_out_t           none;
    logic [2:0]         cmd;
    logic signed [31:0] value;
    mix_t               mix;
    int                 seg_left;
    int                 idle_pct;
    int                 push_pct;
    int                 roll;
    int                 sent;

    none     = '0;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_item  = '0;
    want_fixed   = 1'b0;
    fixed_result = '0;

    // Directed table. Typed-in results are the obvious ones: empty-queue
    // errors, ignored codes, plain pushes and pushes into a full queue.
    add_row(CMD_POP_FRONT,  32'sd0, 1, 1'b1, 32'sd0, STAT_EMPTY);
    add_row(CMD_POP_BACK,   32'sd0, 1, 1'b1, 32'sd0, STAT_EMPTY);
    add_row(CMD_PEEK_FRONT, -32'sd1, 1, 1'b1, 32'sd0, STAT_EMPTY);
    add_row(CMD_PEEK_BACK,  -32'sd1, 1, 1'b1, 32'sd0, STAT_EMPTY);
    add_row(CMD_UNUSED_6,   32'sh7fff_ffff, 1, 1'b1, 32'sd0, STAT_OK);
    add_row(CMD_UNUSED_7,   32'sh8000_0000, 1, 1'b1, 32'sd0, STAT_OK);
    add_row(CMD_PUSH_BACK,  32'sh7fff_ffff, 1, 1'b1, 32'sd0, STAT_OK);
    add_row(CMD_PUSH_FRONT, 32'sh8000_0000, 1, 1'b1, 32'sd0, STAT_OK);  // front wraps
    add_row(CMD_PEEK_FRONT, 32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_PEEK_BACK,  32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_POP_BACK,   32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_POP_FRONT,  32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    // last pop must leave the queue truly empty
    add_row(CMD_PEEK_BACK,  32'sd0, 1, 1'b1, 32'sd0, STAT_EMPTY);
    add_row(CMD_PUSH_BACK,  32'sh5a5a_0000, DEQ_DEPTH, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_PUSH_FRONT, 32'sh1234_5678, 1, 1'b1, 32'sd0, STAT_FULL);
    add_row(CMD_PUSH_BACK,  -32'sd1, 1, 1'b1, 32'sd0, STAT_FULL);
    add_row(CMD_PEEK_FRONT, 32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_PEEK_BACK,  32'sd0, 1, 1'b0, 32'sd0, STAT_OK);
    add_row(CMD_POP_BACK,   32'sd0, 1, 1'b0, 32'sd0, STAT_OK);  // back wraps
    add_row(CMD_POP_FRONT,  32'sd0, 1, 1'b0, 32'sd0, STAT_OK);

    // synchronous reset, released on a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++) begin
        idle_gap(30);
        send_command(row.cmd, row.value + k, row.fixed, row.want);
      end
    end

    // Random traffic in segments; each segment picks a push bias and an
    // idle rate, so some stretches run back to back.
    seg_left = 0;
    mix      = MIX_EVEN;
    idle_pct = 0;
    sent     = 0;
    while (sent < RANDOM_COMMANDS) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       mix = MIX_FILL;
          1:       mix = MIX_DRAIN;
          default: mix = MIX_EVEN;
        endcase
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 35;
      end
      seg_left--;

      case (mix)
        MIX_FILL:  push_pct = 80;
        MIX_DRAIN: push_pct = 20;
        default:   push_pct = 50;
      endcase

      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        cmd = roll[0] ? CMD_UNUSED_7 : CMD_UNUSED_6;  // noise, not counted
      end else begin
        sent++;
        if ($urandom_range(0, 99) < push_pct) begin
          cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        end else begin
          case ($urandom_range(0, 3))
            0:       cmd = CMD_POP_FRONT;
            1:       cmd = CMD_POP_BACK;
            2:       cmd = CMD_PEEK_FRONT;
            default: cmd = CMD_PEEK_BACK;
          endcase
        end
      end

      // extremes now and then, otherwise any 32-bit pattern
      case ($urandom_range(0, 7))
        0:       value = 32'sh7fff_ffff;
        1:       value = 32'sh8000_0000;
        2:       value = 32'sd0;
        3:       value = -32'sd1;
        default: value = $urandom;
      endcase

      idle_gap((sent > RANDOM_COMMANDS - QUIET_TAIL) ? 0 : idle_pct);
      send_command(cmd, value, 1'b0, none);
    end
    start <= 1'b0;

    // wait out the results in flight, then watch for stray strobes
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
